### rtl/wildcard_pattern_matcher_unit_assert.svh
// Assertion macros used by the matcher's checker file.
// Each macro wraps one concurrent assertion clocked on clk, muted in reset.
`ifndef WILDCARD_PATTERN_MATCHER_UNIT_ASSERT_SVH
`define WILDCARD_PATTERN_MATCHER_UNIT_ASSERT_SVH

// same-cycle implication
`define WPM_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define WPM_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/wpm_pkg.sv
// Shared types and constants of the wildcard pattern matcher.
// No dependencies.
`default_nettype none

package wpm_pkg;

	localparam int MAX_PATTERN = 64;
	localparam int LEN_W       = $clog2(MAX_PATTERN + 1);
	localparam int POS_W       = 32;
	localparam int SYM_W       = 8;

	localparam logic [SYM_W-1:0] WILDCARD = 8'd63;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_TEXT   = 2'd2
	} opcode_t;

	// control broadcast to every cell of the chain
	typedef struct packed {
		logic             clr;
		logic             app;
		logic             txt;
	} cell_ctrl_t;

endpackage

`default_nettype wire

### rtl/wpm_cell.sv
// One cell of the comparison chain: a pattern slot and a text window slot.
// Depends on wpm_pkg. Both slots shift toward index zero.
`default_nettype none

module wpm_cell import wpm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire cell_ctrl_t       ctrl,
	input  wire logic [SYM_W-1:0] pat_in,
	input  wire logic             pact_in,
	input  wire logic [SYM_W-1:0] txt_in,
	input  wire logic             tval_in,
	output logic      [SYM_W-1:0] pat,
	output logic                  pact,
	output logic      [SYM_W-1:0] txt,
	output logic                  tval,
	output logic                  ok
);

	logic [SYM_W-1:0] pat_q;
	logic [SYM_W-1:0] txt_q;
	logic             pact_q;
	logic             tval_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pact_q <= 1'b0;
			tval_q <= 1'b0;
		end else if (ctrl.clr) begin
			pact_q <= 1'b0;
			tval_q <= 1'b0;
		end else if (ctrl.app) begin
			pact_q <= pact_in;
		end else if (ctrl.txt) begin
			tval_q <= tval_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.app && !ctrl.clr) begin
			pat_q <= pat_in;
		end
		if (ctrl.txt && !ctrl.clr) begin
			txt_q <= txt_in;
		end
	end

	assign pat  = pat_q;
	assign pact = pact_q;
	assign txt  = txt_q;
	assign tval = tval_q;

	// an unused slot always agrees; a used one needs a real byte that fits
	assign ok = !pact_q || (tval_q && ((pat_q == WILDCARD) || (pat_q == txt_q)));

endmodule

`default_nettype wire

### rtl/wpm_outq.sv
// Two-word result queue that parts the match stage from the output port.
// Depends on wpm_pkg.
`default_nettype none

module wpm_outq import wpm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [POS_W-1:0] push_data,
	output logic                  can_push,
	output logic                  full,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [POS_W-1:0] match_start
);

	logic [POS_W-1:0] mem_q [2];
	logic [1:0]       cnt_q;
	logic             head_q;
	logic             tail_q;
	logic             pop;

	assign out_valid   = (cnt_q != 2'd0);
	assign pop         = out_valid && out_ready;
	assign full        = (cnt_q == 2'd2);
	assign can_push    = !full || pop;
	assign match_start = mem_q[head_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
			tail_q <= 1'b0;
		end else begin
			if (push) begin
				tail_q <= ~tail_q;
			end
			if (pop) begin
				head_q <= ~head_q;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[tail_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

### rtl/wildcard_pattern_matcher_unit.sv
// The chain of MAX_PATTERN cells compares the whole window in the cycle after each text
// word; a match start then goes through the two-word result queue, which absorbs output
// stalls, to the output port. One word per cycle while in_ready is high.
// Reset (arst_n low): pattern empty, text position zero, result queue empty.
`default_nettype none

module wildcard_pattern_matcher_unit import wpm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [1:0]       opcode,
	input  wire logic [SYM_W-1:0] symbol,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [POS_W-1:0] match_start
);

	logic [LEN_W-1:0] len_q;
	logic [POS_W-1:0] pos_q;
	logic             txt_s1;
	logic [POS_W-1:0] start_s1;

	logic             accept;
	logic             pat_full;
	cell_ctrl_t       ctrl;

	logic [SYM_W-1:0] pat   [MAX_PATTERN+1];
	logic             pact  [MAX_PATTERN+1];
	logic [SYM_W-1:0] txt   [MAX_PATTERN+1];
	logic             tval  [MAX_PATTERN+1];
	logic [MAX_PATTERN-1:0] ok;

	logic s1_match;
	logic push;
	logic can_push;
	logic q_full;

	assign accept   = in_valid && in_ready;
	assign pat_full = (len_q == LEN_W'(MAX_PATTERN));

	always_comb begin
		ctrl = '0;
		if (accept) begin
			case (opcode)
				OP_CLEAR:  ctrl.clr = 1'b1;
				OP_APPEND: ctrl.app = !pat_full;
				OP_TEXT:   ctrl.txt = 1'b1;
				default:   ctrl = '0;
			endcase
		end
	end

	// new words enter at the top cell and move toward cell zero
	assign pat[MAX_PATTERN]  = symbol;
	assign pact[MAX_PATTERN] = 1'b1;
	assign txt[MAX_PATTERN]  = symbol;
	assign tval[MAX_PATTERN] = 1'b1;

	for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
		wpm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.pat_in  (pat[j+1]),
			.pact_in (pact[j+1]),
			.txt_in  (txt[j+1]),
			.tval_in (tval[j+1]),
			.pat     (pat[j]),
			.pact    (pact[j]),
			.txt     (txt[j]),
			.tval    (tval[j]),
			.ok      (ok[j])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			pos_q <= '0;
		end else if (ctrl.clr) begin
			len_q <= '0;
			pos_q <= '0;
		end else begin
			if (ctrl.app) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (ctrl.txt) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// the chain state after a text word is judged in the following cycle
	assign s1_match = txt_s1 && (len_q != '0) && (&ok);
	assign push     = s1_match && can_push;
	assign in_ready = !(s1_match && q_full);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_s1 <= 1'b0;
		end else if (accept) begin
			txt_s1 <= ctrl.txt;
		end else if (push) begin
			txt_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.txt) begin
			start_s1 <= pos_q - (POS_W'(len_q) - POS_W'(1));
		end
	end

	wpm_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_data   (start_s1),
		.can_push    (can_push),
		.full        (q_full),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match_start (match_start)
	);

endmodule

`default_nettype wire

### rtl/wpm_checker.sv
// Port-level checker for the wildcard pattern matcher, bound to the top level.
// Depends on wpm_pkg and wildcard_pattern_matcher_unit_assert.svh.
`default_nettype none

`include "wildcard_pattern_matcher_unit_assert.svh"

module wpm_checker import wpm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_ready,
	input  wire logic [1:0]       opcode,
	input  wire logic             out_valid,
	input  wire logic             out_ready,
	input  wire logic [POS_W-1:0] match_start
);

	logic text_acc;

	assign text_acc = in_valid && in_ready && (opcode == OP_TEXT);

	`WPM_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result word dropped while stalled")
	`WPM_ASSERT_NXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable(match_start), "result word changed while stalled")
	`WPM_ASSERT_IMP(a_rose_from_text, clk, arst_n, $rose(out_valid), $past(text_acc, 2), "result without a text word two cycles earlier")
	`WPM_ASSERT_IMP(a_stall_only_full, clk, arst_n, !in_ready, out_valid, "input stalled with an empty result queue")

endmodule

bind wildcard_pattern_matcher_unit wpm_checker u_wpm_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_ready    (in_ready),
	.opcode      (opcode),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.match_start (match_start)
);

`default_nettype wire

### sim/match_start_checker.sv
// Scoreboard for the wildcard pattern matcher: follows pattern and text words,
// predicts every match start and compares it with the output channel.
// Depends on wpm_pkg for widths, opcodes and the wildcard byte.
module match_start_checker import wpm_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [1:0]       opcode,
	input  logic [SYM_W-1:0] symbol,
	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [POS_W-1:0] match_start,
	output int               mismatches,
	output int               starts_pending
);
	logic [SYM_W-1:0] pattern_bytes [MAX_PATTERN];
	logic [SYM_W-1:0] recent_text [MAX_PATTERN];
	int unsigned      pattern_count = 0;
	int unsigned      text_seen = 0;
	logic [POS_W-1:0] next_index = '0;
	logic [POS_W-1:0] expected_starts [$];
	logic [POS_W-1:0] oldest;
	int               fail_count = 0;
	bit               hit;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_count = 0;
			text_seen = 0;
			next_index = '0;
			foreach (pattern_bytes[i]) pattern_bytes[i] = '0;
			foreach (recent_text[i]) recent_text[i] = '0;
			expected_starts.delete();
			starts_pending <= 0;
			mismatches <= fail_count;
		end else begin
			if (in_valid && in_ready) begin
				case (opcode)
					OP_CLEAR: begin
						pattern_count = 0;
						text_seen = 0;
						next_index = '0;
						foreach (recent_text[i]) recent_text[i] = '0;
					end
					OP_APPEND: begin
						// drop symbols once the pattern is full
						if (pattern_count < MAX_PATTERN) begin
							pattern_bytes[pattern_count] = symbol;
							pattern_count++;
						end
					end
					OP_TEXT: begin
						for (int i = 0; i < MAX_PATTERN - 1; i++)
							recent_text[i] = recent_text[i + 1];
						recent_text[MAX_PATTERN - 1] = symbol;
						if (text_seen < MAX_PATTERN)
							text_seen++;
						// compare the pattern as it stands now with the newest bytes
						if (pattern_count != 0 && text_seen >= pattern_count) begin
							hit = 1'b1;
							for (int k = 0; k < pattern_count; k++)
								if (pattern_bytes[k] != WILDCARD &&
										pattern_bytes[k] != recent_text[MAX_PATTERN - pattern_count + k])
									hit = 1'b0;
							if (hit)
								expected_starts.insert(expected_starts.size(),
									next_index - POS_W'(pattern_count - 1));
						end
						next_index++;
					end
					default: begin
					end
				endcase
			end
			if (out_valid && out_ready) begin
				if (expected_starts.size() == 0) begin
					$error("match_start: expected none, actual %0d", match_start);
					fail_count++;
				end else begin
					oldest = expected_starts.pop_front();
					if (match_start !== oldest) begin
						$error("match_start: expected %0d, actual %0d", oldest, match_start);
						fail_count++;
					end
				end
			end
			starts_pending <= expected_starts.size();
			mismatches <= fail_count;
		end
	end

endmodule

### sim/tb.sv
// Top of the wildcard pattern matcher regression: drives pattern and text words,
// throttles both channels and reports the verdict.
// Depends on wpm_pkg, wildcard_pattern_matcher_unit and match_start_checker.
module tb;
	import wpm_pkg::*;

	localparam logic [1:0] OP_UNUSED    = 2'd3;
	localparam int         RANDOM_WORDS = 900;
	localparam int         HOLD_LEN     = 300;
	localparam int         CYCLE_LIMIT  = 200000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [1:0]       opcode = OP_CLEAR;
	logic [SYM_W-1:0] symbol = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [POS_W-1:0] match_start;

	int mismatches;
	int starts_pending;
	int words_sent = 0;
	int send_gap_pct = 0;
	int stall_pct = 0;
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int cycle_count = 0;

	wildcard_pattern_matcher_unit DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.opcode      (opcode),
		.symbol      (symbol),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.match_start (match_start)
	);

	match_start_checker CHK (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.opcode         (opcode),
		.symbol         (symbol),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.match_start    (match_start),
		.mismatches     (mismatches),
		.starts_pending (starts_pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver: random stalls, plus a long hold-off whenever one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_requests != holds_served) begin
			holds_served <= hold_requests;
			hold_left <= HOLD_LEN;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	task automatic send_word(input logic [1:0] op, input logic [SYM_W-1:0] sym);
		while ($urandom_range(99) < send_gap_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		symbol <= sym;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (op != OP_UNUSED)
			words_sent++;
	endtask

	task automatic wait_for_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (starts_pending != 0) @(posedge clk);
	endtask

	// one pattern followed by text that often embeds copies of it
	task automatic send_sequence();
		logic [SYM_W-1:0] pattern_copy [$];
		logic [SYM_W-1:0] letters [4];
		logic [SYM_W-1:0] letter;
		bit               narrow;
		int               pick;
		int               plen;
		int               tlen;
		int               k;
		foreach (letters[i]) letters[i] = SYM_W'($urandom);
		narrow = ($urandom_range(3) != 0);
		pick = $urandom_range(99);
		if (pick < 4)
			plen = $urandom_range(60, 70);
		else if (pick < 10)
			plen = 0;
		else
			plen = $urandom_range(1, 6);
		tlen = (plen > 40) ? $urandom_range(plen, plen + 40) : $urandom_range(4, 30);
		if ($urandom_range(99) < 85)
			send_word(OP_CLEAR, SYM_W'($urandom));
		repeat (plen) begin
			letter = ($urandom_range(3) == 0) ? WILDCARD : letters[$urandom_range(narrow ? 1 : 3)];
			pattern_copy.insert(pattern_copy.size(), letter);
			send_word(OP_APPEND, letter);
		end
		k = pattern_copy.size();
		repeat (tlen) begin
			if (k >= pattern_copy.size() && $urandom_range(2) == 0)
				k = 0;
			letter = letters[$urandom_range(narrow ? 1 : 3)];
			if (k < pattern_copy.size()) begin
				if (pattern_copy[k] != WILDCARD)
					letter = pattern_copy[k];
				k++;
			end
			send_word(OP_TEXT, letter);
			pick = $urandom_range(99);
			// break the sequence now and then: stray words and pattern growth
			if (pick < 4)
				send_word(2'($urandom_range(3)), SYM_W'($urandom));
			else if (pick < 7)
				send_word(OP_APPEND, letters[$urandom_range(3)]);
		end
	endtask

	initial begin
		int phase;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pattern, unused opcode, extremes, partial window, growth mid-text
		send_word(OP_TEXT, 8'h00);
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_UNUSED, 8'hAA);
		send_word(OP_APPEND, 8'hFF);
		send_word(OP_APPEND, WILDCARD);
		send_word(OP_TEXT, 8'hFF);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_CLEAR, 8'h55);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_APPEND, WILDCARD);
		send_word(OP_APPEND, WILDCARD);
		send_word(OP_TEXT, 8'h01);
		send_word(OP_TEXT, 8'h80);
		send_word(OP_APPEND, 8'h00);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_TEXT, 8'h7F);
		send_word(OP_CLEAR, 8'h00);
		send_word(OP_APPEND, 8'h00);
		send_word(OP_TEXT, 8'h00);
		send_word(OP_TEXT, 8'h01);
		send_word(OP_UNUSED, 8'h00);
		send_word(OP_TEXT, 8'h00);
		wait_for_results();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					send_gap_pct = 0;
					stall_pct <= 0;
				end
				1: begin
					send_gap_pct = 57;
					stall_pct <= 0;
				end
				2: begin
					send_gap_pct = 0;
					stall_pct <= 57;
				end
				default: begin
					send_gap_pct = 11;
					stall_pct <= 11;
				end
			endcase
			while (words_sent < 22 + (phase + 1) * RANDOM_WORDS / 4)
				send_sequence();
			wait_for_results();
		end

		// hold the receiver off while an all-wildcard pattern matches every byte
		send_gap_pct = 0;
		stall_pct <= 0;
		hold_requests <= hold_requests + 1;
		send_word(OP_CLEAR, 8'h00);
		repeat (3) send_word(OP_APPEND, WILDCARD);
		repeat (60) send_word(OP_TEXT, SYM_W'($urandom));
		wait_for_results();

		repeat (20) @(posedge clk);
		if (mismatches == 0 && starts_pending == 0)
			$display("wildcard_pattern_matcher_unit regression: pass");
		else
			$display("wildcard_pattern_matcher_unit regression: fail");
		$finish;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("wildcard_pattern_matcher_unit regression: fail");
		$finish;
	end

endmodule
